[rtl/bbe_pkg.sv]
// Shared types, constants and character tables for the Bubble Babble encoder.
package bbe_pkg;

    localparam int unsigned CMD_Q_DEPTH = 2;
    localparam int unsigned CMD_Q_PTR_W = (CMD_Q_DEPTH > 1) ? $clog2(CMD_Q_DEPTH) : 1;
    localparam int unsigned CMD_Q_CNT_W = $clog2(CMD_Q_DEPTH + 1);

    localparam logic [7:0] CHAR_MARK = 8'h78;   // 'x'
    localparam logic [7:0] CHAR_DASH = 8'h2d;   // '-'
    localparam logic [5:0] SEED_INIT = 6'd1;
    localparam logic [6:0] SEED_MOD  = 7'd36;
    localparam logic [3:0] VOWEL_CNT = 4'd6;

    // One message step as seen by the character generator
    typedef struct packed {
        logic       lead;       // emit the leading mark
        logic       pair;       // emit the six characters of a byte pair
        logic       tail;       // emit the closing tuple and the closing mark
        logic       tail_held;  // closing tuple comes from the odd trailing byte
        logic [7:0] b1;         // first byte of the pair, or the trailing byte
        logic [7:0] b2;         // second byte of the pair
        logic [5:0] pseed;      // seed in force for the pair or the held tail
        logic [5:0] tseed;      // seed in force for the closing tuple
    } cmd_t;

    // Reduce a byte modulo 36: split at bit 5, fold the upper part by a table
    function automatic logic [5:0] mod36_byte(input logic [7:0] x);
        logic [5:0] hi_part;
        logic [6:0] t;
        case (x[7:5])
            3'd0:    hi_part = 6'd0;
            3'd1:    hi_part = 6'd32;
            3'd2:    hi_part = 6'd28;
            3'd3:    hi_part = 6'd24;
            3'd4:    hi_part = 6'd20;
            3'd5:    hi_part = 6'd16;
            3'd6:    hi_part = 6'd12;
            default: hi_part = 6'd8;
        endcase
        t = {1'b0, hi_part} + {2'b00, x[4:0]};
        if (t >= SEED_MOD)
            t = t - SEED_MOD;
        return t[5:0];
    endfunction

    // Sum of two residues modulo 36
    function automatic logic [5:0] add_mod36(input logic [5:0] a, input logic [5:0] b);
        logic [6:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= SEED_MOD)
            s = s - SEED_MOD;
        return s[5:0];
    endfunction

    // Seed divided by 6, valid for seeds below 36 (reciprocal multiply)
    function automatic logic [2:0] div6(input logic [5:0] s);
        logic [11:0] p;
        p = {6'd0, s} * 12'd43;
        return p[10:8];
    endfunction

    // Seed modulo 6, valid for seeds below 36
    function automatic logic [2:0] rem6(input logic [5:0] s);
        logic [2:0] q;
        logic [5:0] r;
        q = div6(s);
        r = s - ({1'b0, q, 2'b00} + {2'b00, q, 1'b0});
        return r[2:0];
    endfunction

    function automatic logic [7:0] vowel(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = "a";
            3'd1:    c = "e";
            3'd2:    c = "i";
            3'd3:    c = "o";
            3'd4:    c = "u";
            3'd5:    c = "y";
            default: c = "a";
        endcase
        return c;
    endfunction

    // Vowel at (a + b) mod 6, both operands below 6
    function automatic logic [7:0] vowel_mod(input logic [2:0] a, input logic [2:0] b);
        logic [3:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= VOWEL_CNT)
            s = s - VOWEL_CNT;
        return vowel(s[2:0]);
    endfunction

    function automatic logic [7:0] cons(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = "b";
            4'd1:    c = "c";
            4'd2:    c = "d";
            4'd3:    c = "f";
            4'd4:    c = "g";
            4'd5:    c = "h";
            4'd6:    c = "k";
            4'd7:    c = "l";
            4'd8:    c = "m";
            4'd9:    c = "n";
            4'd10:   c = "p";
            4'd11:   c = "r";
            4'd12:   c = "s";
            4'd13:   c = "t";
            4'd14:   c = "v";
            default: c = "z";
        endcase
        return c;
    endfunction

endpackage

[rtl/bbe_front.sv]
// Input side: accepts message bytes, tracks seed and pairing, issues commands.
module bbe_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_ready,
    input  logic [7:0]    data_byte,
    input  logic          is_last,
    input  logic          empty_message,
    input  logic          fifo_full,
    output logic          push,
    output bbe_pkg::cmd_t push_cmd
);
    import bbe_pkg::*;

    logic [5:0] seed_reg, seed_next;
    logic       holding_reg, holding_next;
    logic       started_reg, started_next;
    logic [7:0] held_reg;
    logic [5:0] partial_reg;     // (5*seed + 7*held) mod 36, taken when a byte is held

    logic       accept;
    logic       pair;
    logic       hold_new;
    logic       tail;
    logic       holding_after;
    logic [5:0] pair_seed;
    logic [5:0] seed_after;
    logic [5:0] partial_new;
    logic [7:0] seed_x5;
    logic [7:0] byte_x7;
    logic [5:0] byte_res;

    assign item_ready = !fifo_full;
    assign accept     = item_valid && item_ready;

    // Classify the item against the current message state
    always_comb
    begin
        pair          = !empty_message && holding_reg;
        hold_new      = !empty_message && !holding_reg;
        tail          = empty_message || is_last;
        holding_after = empty_message ? holding_reg : hold_new;
    end

    // Seed arithmetic: partial term prepared at hold time, finished on the pair
    always_comb
    begin
        seed_x5     = {2'b00, seed_reg} + {seed_reg, 2'b00};
        byte_res    = mod36_byte(data_byte);
        byte_x7     = {byte_res, 2'b00} + {1'b0, byte_res, 1'b0} + {2'b00, byte_res};
        partial_new = add_mod36(mod36_byte(seed_x5), mod36_byte(byte_x7));
        pair_seed   = add_mod36(partial_reg, byte_res);
        seed_after  = pair ? pair_seed : seed_reg;
    end

    // Build the command for the character generator
    always_comb
    begin
        push_cmd.lead      = !started_reg;
        push_cmd.pair      = pair;
        push_cmd.tail      = tail;
        push_cmd.tail_held = tail && holding_after;
        push_cmd.b1        = holding_reg ? held_reg : data_byte;
        push_cmd.b2        = data_byte;
        push_cmd.pseed     = seed_reg;
        push_cmd.tseed     = seed_after;
        push = accept && (!started_reg || pair || tail);
    end

    // Next message state
    always_comb
    begin
        seed_next    = seed_reg;
        holding_next = holding_reg;
        started_next = started_reg;
        if (accept)
        begin
            if (tail)
            begin
                seed_next    = SEED_INIT;
                holding_next = 1'b0;
                started_next = 1'b0;
            end
            else
            begin
                seed_next    = seed_after;
                holding_next = holding_after;
                started_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg    <= SEED_INIT;
            holding_reg <= 1'b0;
            started_reg <= 1'b0;
        end
        else
        begin
            seed_reg    <= seed_next;
            holding_reg <= holding_next;
            started_reg <= started_next;
        end
    end

    // Capture the first byte of a pair and its seed term
    always_ff @(posedge clk)
    begin
        if (accept && hold_new)
        begin
            held_reg    <= data_byte;
            partial_reg <= partial_new;
        end
    end

endmodule

[rtl/bbe_cmd_fifo.sv]
// Short command queue between the input side and the character generator.
module bbe_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bbe_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          q_valid,
    output bbe_pkg::cmd_t q_cmd
);
    import bbe_pkg::*;

    cmd_t                   mem_reg [CMD_Q_DEPTH];
    logic [CMD_Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_Q_CNT_W-1:0] count_reg, count_next;
    logic                   do_push;
    logic                   do_pop;

    assign full    = (count_reg == CMD_Q_CNT_W'(CMD_Q_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_cmd   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == CMD_Q_PTR_W'(CMD_Q_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == CMD_Q_PTR_W'(CMD_Q_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming command
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

[rtl/bbe_back.sv]
// Character generator: expands each command into characters, one per cycle while the receiver takes them.
module bbe_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  bbe_pkg::cmd_t q_cmd,
    output logic          pop,
    output logic          char_valid,
    input  logic          char_ready,
    output logic [7:0]    out_char,
    output logic          last_char
);
    import bbe_pkg::*;

    typedef enum logic [3:0] {
        SLOT_LEAD,
        SLOT_H0,
        SLOT_H1,
        SLOT_H2,
        SLOT_P0,
        SLOT_DASH,
        SLOT_P1,
        SLOT_T0,
        SLOT_T1,
        SLOT_T2,
        SLOT_CLOSE
    } slot_t;

    slot_t      slot_reg, slot_next;
    logic       busy_reg, busy_next;
    cmd_t       cmd_reg, cmd_next;
    logic       char_valid_reg, char_valid_next;
    logic [7:0] out_char_reg, out_char_next;
    logic       last_char_reg, last_char_next;

    logic       adv;
    logic       final_slot;
    slot_t      first_slot;
    slot_t      step_slot;
    logic [7:0] tail_byte;
    logic [2:0] hq, hr, tq, tr;
    logic [7:0] ch;
    logic       ch_last;

    assign char_valid = char_valid_reg;
    assign out_char   = out_char_reg;
    assign last_char  = last_char_reg;

    // Produce a character while a command is in progress and the output register is free or draining
    assign adv = busy_reg && (!char_valid_reg || char_ready);

    always_comb
    begin
        final_slot = (slot_reg == SLOT_CLOSE)
                  || (slot_reg == SLOT_P1 && !cmd_reg.tail)
                  || (slot_reg == SLOT_LEAD && !cmd_reg.pair && !cmd_reg.tail);
        pop = q_valid && (!busy_reg || (adv && final_slot));
    end

    // Pick the first and the following slot of a command
    always_comb
    begin
        if (q_cmd.lead)
            first_slot = SLOT_LEAD;
        else if (q_cmd.pair)
            first_slot = SLOT_H0;
        else
            first_slot = SLOT_T0;

        case (slot_reg)
            SLOT_LEAD: step_slot = cmd_reg.pair ? SLOT_H0 : SLOT_T0;
            SLOT_H0:   step_slot = SLOT_H1;
            SLOT_H1:   step_slot = SLOT_H2;
            SLOT_H2:   step_slot = SLOT_P0;
            SLOT_P0:   step_slot = SLOT_DASH;
            SLOT_DASH: step_slot = SLOT_P1;
            SLOT_P1:   step_slot = SLOT_T0;
            SLOT_T0:   step_slot = SLOT_T1;
            SLOT_T1:   step_slot = SLOT_T2;
            SLOT_T2:   step_slot = SLOT_CLOSE;
            default:   step_slot = SLOT_CLOSE;
        endcase
    end

    // Character for the current slot; a seed-only tail acts as a zero byte with an 'x' in the middle
    always_comb
    begin
        tail_byte = cmd_reg.tail_held ? cmd_reg.b1 : 8'd0;
        hq        = div6(cmd_reg.pseed);
        hr        = rem6(cmd_reg.pseed);
        tq        = div6(cmd_reg.tseed);
        tr        = rem6(cmd_reg.tseed);
        ch_last   = 1'b0;
        case (slot_reg)
            SLOT_LEAD: ch = CHAR_MARK;
            SLOT_H0:   ch = vowel_mod({1'b0, cmd_reg.b1[7:6]}, hr);
            SLOT_H1:   ch = cons(cmd_reg.b1[5:2]);
            SLOT_H2:   ch = vowel_mod({1'b0, cmd_reg.b1[1:0]}, hq);
            SLOT_P0:   ch = cons(cmd_reg.b2[7:4]);
            SLOT_DASH: ch = CHAR_DASH;
            SLOT_P1:   ch = cons(cmd_reg.b2[3:0]);
            SLOT_T0:   ch = vowel_mod({1'b0, tail_byte[7:6]}, tr);
            SLOT_T1:   ch = cmd_reg.tail_held ? cons(tail_byte[5:2]) : CHAR_MARK;
            SLOT_T2:   ch = vowel_mod({1'b0, tail_byte[1:0]}, tq);
            SLOT_CLOSE:
            begin
                ch      = CHAR_MARK;
                ch_last = 1'b1;
            end
            default:   ch = CHAR_MARK;
        endcase
    end

    // Next sequencer and output register values
    always_comb
    begin
        busy_next       = busy_reg;
        slot_next       = slot_reg;
        cmd_next        = cmd_reg;
        char_valid_next = char_valid_reg;
        out_char_next   = out_char_reg;
        last_char_next  = last_char_reg;

        if (adv)
        begin
            char_valid_next = 1'b1;
            out_char_next   = ch;
            last_char_next  = ch_last;
        end
        else if (char_ready)
        begin
            char_valid_next = 1'b0;
        end

        if (pop)
        begin
            busy_next = 1'b1;
            cmd_next  = q_cmd;
            slot_next = first_slot;
        end
        else if (adv && final_slot)
        begin
            busy_next = 1'b0;
        end
        else if (adv)
        begin
            slot_next = step_slot;
        end
    end

    // Hold sequencer state and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            slot_reg       <= SLOT_LEAD;
            cmd_reg        <= '0;
            char_valid_reg <= 1'b0;
            out_char_reg   <= '0;
            last_char_reg  <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            slot_reg       <= slot_next;
            cmd_reg        <= cmd_next;
            char_valid_reg <= char_valid_next;
            out_char_reg   <= out_char_next;
            last_char_reg  <= last_char_next;
        end
    end

endmodule

[rtl/bubble_babble_encoder_top.sv]
// Top level of the Bubble Babble encoder.
//
// Input channel (item_valid/item_ready): one message byte per transfer, with
// is_last on the final byte; empty_message ends the current message without a
// byte, or encodes a zero-length message ("xexax") when none is open.
// Output channel (char_valid/char_ready): one ASCII character per transfer;
// last_char marks the closing 'x' of each message.
// Throughput: one character per cycle while the receiver takes them and commands
// are queued, set by the single character generator; a byte pair yields six
// characters, and each message adds the leading 'x', the closing tuple and the
// closing 'x'. The input side runs ahead through a two-entry command queue and
// takes bytes every cycle while the queue has room; bytes that complete no output
// (the first byte of a pair mid-message) push no command.
// When the receiver stalls, the output register holds its character, the
// generator and then the queue fill, and item_ready drops.
// Reset: the seed returns to 1, no message is open, queue and output are empty.
module bubble_babble_encoder_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [7:0] data_byte,
    input  logic       is_last,
    input  logic       empty_message,
    output logic       char_valid,
    input  logic       char_ready,
    output logic [7:0] out_char,
    output logic       last_char
);
    import bbe_pkg::*;

    logic fifo_full;
    logic push;
    cmd_t push_cmd;
    logic pop;
    logic q_valid;
    cmd_t q_cmd;

    bbe_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .data_byte     (data_byte),
        .is_last       (is_last),
        .empty_message (empty_message),
        .fifo_full     (fifo_full),
        .push          (push),
        .push_cmd      (push_cmd)
    );

    bbe_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (fifo_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    bbe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd),
        .pop        (pop),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .out_char   (out_char),
        .last_char  (last_char)
    );

endmodule

[rtl/bbe_checker.sv]
// Port-level checks for the Bubble Babble encoder, bound to the top level.
module bbe_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       char_valid,
    input logic       char_ready,
    input logic [7:0] out_char,
    input logic       last_char
);

    // Output transfer is held while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && !char_ready |=> char_valid)
        else $error("char_valid dropped before transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && !char_ready |=> $stable(out_char) && $stable(last_char))
        else $error("output character changed while stalled");

    // The message end marker is always the closing x
    assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && last_char |-> out_char == 8'h78)
        else $error("last_char on a character other than x");

    // Only lowercase letters and the dash appear in the text
    assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> (out_char >= 8'h61 && out_char <= 8'h7a) || out_char == 8'h2d)
        else $error("character outside the encoding alphabet");

endmodule

bind bubble_babble_encoder_top bbe_checker u_bbe_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .out_char   (out_char),
    .last_char  (last_char)
);

[bench/bubble_babble_checker.sv]
// Checker for the Bubble Babble encoder: predicts the encoded text and compares it.
`timescale 1ns / 100ps

module bubble_babble_checker
    import bbe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic       item_ready,
    input  logic [7:0] data_byte,
    input  logic       is_last,
    input  logic       empty_message,
    input  logic       char_valid,
    input  logic       char_ready,
    input  logic [7:0] out_char,
    input  logic       last_char,
    output int         fail_count,
    output int         pending,
    output int         byte_count,
    output int         char_count,
    output int         message_count
);

    localparam logic [47:0]  VOWELS     = "aeiouy";
    localparam logic [127:0] CONSONANTS = "bcdfghklmnprstvz";

    typedef struct packed {
        logic [7:0] ch;
        logic       closing;
    } text_char_t;

    text_char_t expected_text[$];

    // Encoder state as the predictor sees it
    logic [5:0] seed_r;
    logic [7:0] held_r;
    logic       holding_r;
    logic       started_r;

    int mismatches;
    int n_bytes;
    int n_chars;
    int n_messages;

    function automatic logic [7:0] vowel_at(input int idx);
        return VOWELS[8 * (5 - idx) +: 8];
    endfunction

    function automatic logic [7:0] consonant_at(input int idx);
        return CONSONANTS[8 * (15 - idx) +: 8];
    endfunction

    task automatic push_char(input logic [7:0] ch, input logic closing);
        text_char_t c;
        c.ch      = ch;
        c.closing = closing;
        expected_text.push_back(c);
    endtask

    // Append the three characters that the first byte of a pair yields
    task automatic push_pair_head(input logic [7:0] b);
        push_char(vowel_at((int'(b[7:6]) + int'(seed_r)) % 6), 1'b0);
        push_char(consonant_at(int'(b[5:2])), 1'b0);
        push_char(vowel_at((int'(b[1:0]) + int'(seed_r) / 6) % 6), 1'b0);
    endtask

    // Advance the encoder by one input transfer and queue the text it yields
    task automatic encode_byte_step(input logic [7:0] b, input logic fin, input logic empty);
        int  next_seed;
        logic closes;
        closes = fin | empty;
        if (!started_r)
        begin
            push_char(CHAR_MARK, 1'b0);
            started_r = 1'b1;
        end
        if (!empty)
        begin
            if (holding_r)
            begin
                push_pair_head(held_r);
                push_char(consonant_at(int'(b[7:4])), 1'b0);
                push_char(CHAR_DASH, 1'b0);
                push_char(consonant_at(int'(b[3:0])), 1'b0);
                next_seed = (5 * int'(seed_r) + 7 * int'(held_r) + int'(b)) % 36;
                seed_r    = next_seed[5:0];
                holding_r = 1'b0;
            end
            else
            begin
                held_r    = b;
                holding_r = 1'b1;
            end
        end
        if (closes)
        begin
            // Odd trailing byte forms the tuple, else the seed alone with a middle mark
            if (holding_r)
                push_pair_head(held_r);
            else
            begin
                push_char(vowel_at(int'(seed_r) % 6), 1'b0);
                push_char(CHAR_MARK, 1'b0);
                push_char(vowel_at((int'(seed_r) / 6) % 6), 1'b0);
            end
            push_char(CHAR_MARK, 1'b1);
            seed_r    = SEED_INIT;
            holding_r = 1'b0;
            started_r = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        text_char_t exp_c;
        if (!rst_n)
        begin
            expected_text.delete();
            seed_r        = SEED_INIT;
            held_r        = '0;
            holding_r     = 1'b0;
            started_r     = 1'b0;
            mismatches    = 0;
            n_bytes       = 0;
            n_chars       = 0;
            n_messages    = 0;
            fail_count    <= 0;
            pending       <= 0;
            byte_count    <= 0;
            char_count    <= 0;
            message_count <= 0;
        end
        else
        begin
            // Compare each character transfer with the oldest expected one
            if (char_valid && char_ready)
            begin
                n_chars++;
                if (last_char)
                    n_messages++;
                if (expected_text.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected character 0x%02h last=%0b",
                                 $realtime, out_char, last_char);
                end
                else
                begin
                    exp_c = expected_text.pop_front();
                    if (exp_c.ch !== out_char || exp_c.closing !== last_char)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: expected char 0x%02h last=%0b, got 0x%02h last=%0b",
                                     $realtime, exp_c.ch, exp_c.closing, out_char, last_char);
                    end
                end
            end
            // Predict the text caused by an input transfer
            if (item_valid && item_ready)
            begin
                n_bytes++;
                encode_byte_step(data_byte, is_last, empty_message);
            end
            fail_count    <= mismatches;
            pending       <= expected_text.size();
            byte_count    <= n_bytes;
            char_count    <= n_chars;
            message_count <= n_messages;
        end
    end

endmodule

[bench/bubble_babble_encoder_top_tb.sv]
// Testbench top for the Bubble Babble encoder: stimulus, stalls and verdict.
`timescale 1ns / 100ps

module bubble_babble_encoder_top_tb;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       item_valid = 1'b0;
    logic       item_ready;
    logic [7:0] data_byte = '0;
    logic       is_last = 1'b0;
    logic       empty_message = 1'b0;
    logic       char_valid;
    logic       char_ready = 1'b0;
    logic [7:0] out_char;
    logic       last_char;

    int fail_count;
    int pending;
    int byte_count;
    int char_count;
    int message_count;

    int items_sent = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int stall_left = 0;

    bubble_babble_encoder_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .data_byte     (data_byte),
        .is_last       (is_last),
        .empty_message (empty_message),
        .char_valid    (char_valid),
        .char_ready    (char_ready),
        .out_char      (out_char),
        .last_char     (last_char)
    );

    bubble_babble_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .data_byte     (data_byte),
        .is_last       (is_last),
        .empty_message (empty_message),
        .char_valid    (char_valid),
        .char_ready    (char_ready),
        .out_char      (out_char),
        .last_char     (last_char),
        .fail_count    (fail_count),
        .pending       (pending),
        .byte_count    (byte_count),
        .char_count    (char_count),
        .message_count (message_count)
    );

    always #5 clk = ~clk;

    // Bound the run in case the block hangs
    initial
    begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Stall the character receiver at random
    always @(negedge clk)
    begin
        if (!rst_n)
            char_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            char_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            char_ready <= 1'b1;
            if ($urandom_range(0, 99) < stall_pct)
                stall_left = pick_gap();
        end
    end

    // Drive one input item, with an optional gap ahead, and hold until transfer
    task automatic send_item(input logic [7:0] b, input logic fin, input logic empty);
        int gap;
        gap = ($urandom_range(0, 99) < idle_pct) ? pick_gap() : 0;
        repeat (gap)
        begin
            @(negedge clk);
            item_valid    <= 1'b0;
            data_byte     <= 8'($urandom);
            is_last       <= 1'($urandom);
            empty_message <= 1'($urandom);
        end
        @(negedge clk);
        item_valid    <= 1'b1;
        data_byte     <= b;
        is_last       <= fin;
        empty_message <= empty;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Hold the sender until every expected character has arrived
    task automatic wait_drained();
        @(negedge clk);
        item_valid <= 1'b0;
        @(posedge clk);
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int msg_len;
        int pick;
        logic close_empty;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty messages, byte extremes, odd tails, mid-message close
        stall_pct = 30;
        send_item(8'hA5, 1'b0, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h55, 1'b1, 1'b0);
        send_item(8'hAA, 1'b0, 1'b0);
        send_item(8'h55, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h3C, 1'b0, 1'b0);
        send_item(8'hC3, 1'b1, 1'b1);
        send_item(8'h01, 1'b0, 1'b0);
        send_item(8'h02, 1'b0, 1'b0);
        send_item(8'h03, 1'b0, 1'b0);
        send_item(8'h04, 1'b1, 1'b0);
        wait_drained();

        // Random messages, switching idle and stall intensity now and then
        while (items_sent < 160)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                pick = $urandom_range(0, 2);
                idle_pct  = (pick == 0) ? 0 : (pick == 1) ? 25 : 60;
                pick = $urandom_range(0, 2);
                stall_pct = (pick == 0) ? 0 : (pick == 1) ? 20 : 50;
            end
            pick = $urandom_range(0, 99);
            if (pick < 10)
                msg_len = 0;
            else if (pick < 85)
                msg_len = $urandom_range(1, 8);
            else
                msg_len = $urandom_range(9, 20);
            close_empty = ($urandom_range(0, 4) == 0);
            if (msg_len == 0)
                send_item(8'($urandom), 1'($urandom), 1'b1);
            else
            begin
                for (int i = 0; i < msg_len; i++)
                    send_item(8'($urandom), (i == msg_len - 1) && !close_empty, 1'b0);
                if (close_empty)
                    send_item(8'($urandom), 1'($urandom), 1'b1);
            end
            if ($urandom_range(0, 11) == 0)
                wait_drained();
        end

        // Drain, then let any stray characters show up
        wait_drained();
        repeat (20) @(posedge clk);

        $display("Covered %0d input transfers and %0d characters in %0d messages,",
                 byte_count, char_count, message_count);
        $display("directed edge cases then random messages under mixed gaps and stalls.");
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
